// ===== src/msconv_pkg.sv =====
// Shared types and constants for the multichannel strided convolution block.
// Depends on nothing; the other design files except msconv_ram refer to it by scoped names.
`default_nettype none
package msconv_pkg;

  localparam int MAX_DIM      = 32;
  localparam int MAX_K        = 8;
  localparam int MAX_CHANNELS = 16;

  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int KIDX_W  = $clog2(MAX_K);
  localparam int WADDR_W = 2 * KIDX_W;
  localparam int SADDR_W = 2 * DIM_W;
  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int SUM_W   = 40;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W  = 2 * SAMPLE_W;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

  // Input opcodes.
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         weight_row;
    logic [2:0]         weight_col;
    logic signed [15:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [39:0] sum;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic               last;
  } out_t;

  // Configuration after saturation into the legal ranges.
  typedef struct packed {
    logic [3:0] k;
    logic [3:0] s;
    logic [5:0] h;
    logic [5:0] w;
    logic [4:0] c;
  } cfg_t;

  // One accumulator update issued by the sequencer.
  typedef struct packed {
    logic                       valid;
    logic                       emit;
    logic                       last;
    logic [DIM_W-1:0]           row;
    logic [DIM_W-1:0]           col;
    logic [SADDR_W-1:0]         saddr;
    logic [WADDR_W-1:0]         waddr;
    logic signed [SAMPLE_W-1:0] px;
  } upd_t;

  // Clearing pass over the accumulator store.
  typedef struct packed {
    logic               active;
    logic [SADDR_W-1:0] addr;
  } clr_t;

endpackage
`default_nettype wire

// ===== src/multichannel_strided_conv2d.sv =====
// A pixel word is swept over the candidate windows that can hold it, one window
// per cycle, at most 64 of them; a completed window sum passes through the c1
// and c2 pipeline registers and the hold register into the output register.
// Input: a new word, pixel or weight, is taken only in the idle state once the
// pipeline has drained, and not while a result waits in the hold register.
// Reset, and any write to a listed register, runs a clearing pass over all 1024
// accumulator entries during which no input word is taken.
`default_nettype none
module multichannel_strided_conv2d (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire msconv_pkg::in_t   in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output msconv_pkg::out_t       out_data,
  input  wire logic              cfg_we,
  input  wire logic [msconv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [msconv_pkg::CFG_W-1:0]     cfg_data
);

  logic [3:0] kernel_size, stride;
  logic [5:0] map_height, map_width;
  logic [4:0] channel_count;
  msconv_pkg::cfg_t cfg;
  msconv_pkg::upd_t upd;
  msconv_pkg::clr_t clr;
  logic restart, ready, accept, busy;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size <= 4'd3;
      stride <= 4'd1;
      map_height <= 6'd32;
      map_width <= 6'd32;
      channel_count <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msconv_pkg::CFG_KERNEL_SIZE:   kernel_size <= cfg_data[3:0];
        msconv_pkg::CFG_STRIDE:        stride <= cfg_data[3:0];
        msconv_pkg::CFG_MAP_HEIGHT:    map_height <= cfg_data;
        msconv_pkg::CFG_MAP_WIDTH:     map_width <= cfg_data;
        msconv_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Saturate the registers into their legal ranges.
  always_comb begin
    cfg.k = (kernel_size == 4'd0) ? 4'd1 : (kernel_size > 4'd8) ? 4'd8 : kernel_size;
    cfg.s = (stride == 4'd0) ? 4'd1 : stride;
    cfg.h = (map_height == 6'd0) ? 6'd1 : (map_height > 6'd32) ? 6'd32 : map_height;
    cfg.w = (map_width == 6'd0) ? 6'd1 : (map_width > 6'd32) ? 6'd32 : map_width;
    cfg.c = (channel_count == 5'd0) ? 5'd1 :
            (channel_count > 5'd16) ? 5'd16 : channel_count;
    restart = cfg_we && (cfg_index <= msconv_pkg::CFG_CHANNEL_COUNT);
    in_stall = !ready;
    accept = in_valid && ready;
  end

  msconv_seq u_seq (
    .clk(clk), .rst(rst), .cfg(cfg), .restart(restart),
    .start(accept && (in_data.opcode == msconv_pkg::OP_PIXEL)),
    .px(in_data.sample), .pipe_busy(busy), .ready(ready), .upd(upd), .clr(clr)
  );

  msconv_acc u_acc (
    .clk(clk), .rst(rst), .upd(upd), .clr(clr),
    .wt_we(accept && (in_data.opcode == msconv_pkg::OP_WEIGHT)),
    .wt_addr({in_data.weight_row, in_data.weight_col}), .wt_data(in_data.sample),
    .out_stall(out_stall), .out_valid(out_valid), .out_data(out_data), .busy(busy)
  );

`ifndef SYNTHESIS
  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    clr.active |-> !upd.valid) else $error("update issued during clearing pass");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !busy) else $error("word taken while pipeline busy");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    upd.emit |-> upd.valid) else $error("emit on an invalid update");
`endif

endmodule
`default_nettype wire

// ===== src/msconv_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module msconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/msconv_seq.sv =====
// Sequencer: pixel position counters, the walk over the windows holding a
// pixel, and the clearing pass. Depends on msconv_pkg.
`default_nettype none
module msconv_seq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire msconv_pkg::cfg_t      cfg,
  input  wire logic                  restart,
  input  wire logic                  start,
  input  wire logic signed [15:0]    px,
  input  wire logic                  pipe_busy,
  output logic                       ready,
  output msconv_pkg::upd_t           upd,
  output msconv_pkg::clr_t           clr
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_CLEAR = 3'b100
  } seq_state_t;

  seq_state_t state;
  logic [4:0] pos_r, pos_c, row_div, col_div;
  logic [3:0] row_mod, col_mod, chan;
  logic [4:0] cur_r, cur_c, di, dj, wi, wj, col_div0;
  logic [3:0] col_mod0;
  logic       last_ch;
  logic signed [15:0] px_r;
  logic [msconv_pkg::SADDR_W-1:0] clr_addr;

  logic [4:0] k5, s5, r0, c0, di_n, dj_n;
  logic       in_k, row_ok, col_ok, last_r, last_c, row_end, sweep_end;

  // Geometry of the current update.
  always_comb begin
    k5 = {1'b0, cfg.k};
    s5 = {1'b0, cfg.s};
    r0 = cur_r - di;
    c0 = cur_c - dj;
    in_k = (di < k5) && (dj < k5);
    row_ok = ({2'b0, r0} + {3'b0, cfg.k}) <= {1'b0, cfg.h};
    col_ok = ({2'b0, c0} + {3'b0, cfg.k}) <= {1'b0, cfg.w};
    last_r = ({2'b0, r0} + {3'b0, cfg.s} + {3'b0, cfg.k}) > {1'b0, cfg.h};
    last_c = ({2'b0, c0} + {3'b0, cfg.s} + {3'b0, cfg.k}) > {1'b0, cfg.w};
    di_n = di + s5;
    dj_n = dj + s5;
    row_end = (dj_n >= k5) || (wj == 5'd0);
    sweep_end = (di_n >= k5) || (wi == 5'd0);
  end

  // Update and clearing pass issued to the datapath, and the ready flag.
  always_comb begin
    upd.valid = (state == ST_SWEEP) && in_k && row_ok && col_ok;
    upd.emit  = upd.valid && last_ch && (di == k5 - 5'd1) && (dj == k5 - 5'd1);
    upd.last  = last_r && last_c;
    upd.row   = wi;
    upd.col   = wj;
    upd.saddr = {wi, wj};
    upd.waddr = {di[msconv_pkg::KIDX_W-1:0], dj[msconv_pkg::KIDX_W-1:0]};
    upd.px    = px_r;
    clr.active = (state == ST_CLEAR);
    clr.addr   = clr_addr;
    ready      = (state == ST_IDLE) && !pipe_busy;
  end

  // Control state, position counters and the walk.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      pos_r <= '0;
      pos_c <= '0;
      row_mod <= '0;
      col_mod <= '0;
      row_div <= '0;
      col_div <= '0;
      chan <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + {{(msconv_pkg::SADDR_W-1){1'b0}}, 1'b1};
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= ST_SWEEP;
            cur_r <= pos_r;
            cur_c <= pos_c;
            di <= {1'b0, row_mod};
            dj <= {1'b0, col_mod};
            wi <= row_div;
            wj <= col_div;
            col_mod0 <= col_mod;
            col_div0 <= col_div;
            last_ch <= ({1'b0, chan} + 5'd1) >= cfg.c;
            px_r <= px;
            // Advance the raster position.
            if (({1'b0, pos_c} + 6'd1) >= cfg.w) begin
              pos_c <= '0;
              col_mod <= '0;
              col_div <= '0;
              if (({1'b0, pos_r} + 6'd1) >= cfg.h) begin
                pos_r <= '0;
                row_mod <= '0;
                row_div <= '0;
                chan <= (({1'b0, chan} + 5'd1) >= cfg.c) ? 4'd0 : chan + 4'd1;
              end else begin
                pos_r <= pos_r + 5'd1;
                if ((row_mod + 4'd1) >= cfg.s) begin
                  row_mod <= '0;
                  row_div <= row_div + 5'd1;
                end else begin
                  row_mod <= row_mod + 4'd1;
                end
              end
            end else begin
              pos_c <= pos_c + 5'd1;
              if ((col_mod + 4'd1) >= cfg.s) begin
                col_mod <= '0;
                col_div <= col_div + 5'd1;
              end else begin
                col_mod <= col_mod + 4'd1;
              end
            end
          end
        end
        ST_SWEEP: begin
          if (!row_end) begin
            dj <= dj_n;
            wj <= wj - 5'd1;
          end else if (sweep_end) begin
            state <= ST_IDLE;
          end else begin
            di <= di_n;
            wi <= wi - 5'd1;
            dj <= {1'b0, col_mod0};
            wj <= col_div0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/msconv_acc.sv =====
// Datapath: weight and accumulator memories, multiply, read-modify-write
// and the result registers. Depends on msconv_pkg and msconv_ram.
`default_nettype none
module msconv_acc (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire msconv_pkg::upd_t     upd,
  input  wire msconv_pkg::clr_t     clr,
  input  wire logic                 wt_we,
  input  wire logic [msconv_pkg::WADDR_W-1:0] wt_addr,
  input  wire logic signed [15:0]   wt_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output msconv_pkg::out_t          out_data,
  output logic                      busy
);

  msconv_pkg::upd_t c1, c2;
  logic [15:0] wt_rd;
  logic [msconv_pkg::SUM_W-1:0] sum_rd, old2, sum_new, sum_wdata;
  logic signed [msconv_pkg::PROD_W-1:0] prod2;
  logic sum_we;
  logic [msconv_pkg::SADDR_W-1:0] sum_waddr;
  msconv_pkg::out_t hold;
  logic hold_valid;

  msconv_ram #(.WIDTH(msconv_pkg::SAMPLE_W), .DEPTH(msconv_pkg::MAX_K * msconv_pkg::MAX_K))
    u_weights (
      .clk(clk), .we(wt_we), .waddr(wt_addr), .wdata(wt_data),
      .raddr(upd.waddr), .rdata(wt_rd)
    );

  msconv_ram #(.WIDTH(msconv_pkg::SUM_W), .DEPTH(msconv_pkg::MAX_DIM * msconv_pkg::MAX_DIM))
    u_sums (
      .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
      .raddr(upd.saddr), .rdata(sum_rd)
    );

  // Write-back: the clearing pass owns the port while it runs.
  always_comb begin
    sum_new = old2 + {{(msconv_pkg::SUM_W - msconv_pkg::PROD_W){prod2[msconv_pkg::PROD_W-1]}},
                      prod2};
    sum_we = clr.active || c2.valid;
    sum_waddr = clr.active ? clr.addr : c2.saddr;
    sum_wdata = (clr.active || c2.emit) ? '0 : sum_new;
    busy = c1.valid || c2.valid || hold_valid;
  end

  // Pipeline: multiply after the memory reads, then the valid bits and the
  // two result words.
  always_ff @(posedge clk) begin
    c2.emit <= c1.emit;
    c2.last <= c1.last;
    c2.row <= c1.row;
    c2.col <= c1.col;
    c2.saddr <= c1.saddr;
    c2.waddr <= c1.waddr;
    c2.px <= c1.px;
    c1.emit <= upd.emit;
    c1.last <= upd.last;
    c1.row <= upd.row;
    c1.col <= upd.col;
    c1.saddr <= upd.saddr;
    c1.waddr <= upd.waddr;
    c1.px <= upd.px;
    prod2 <= c1.px * $signed(wt_rd);
    old2 <= sum_rd;
    if (rst) begin
      c1.valid <= 1'b0;
      c2.valid <= 1'b0;
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      c1.valid <= upd.valid;
      c2.valid <= c1.valid;
      if (hold_valid && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        out_data <= hold;
        hold_valid <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (c2.valid && c2.emit) begin
        hold_valid <= 1'b1;
        hold.sum <= sum_new;
        hold.out_row <= c2.row;
        hold.out_col <= c2.col;
        hold.last <= c2.last;
      end
    end
  end

endmodule
`default_nettype wire
